[hdl/sobel_pkg.sv]
// Package for the Sobel edge magnitude block: payload structs, register
// indexes, controller states and the command/status bundles.
// No dependencies.
package sobel_pkg;

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_start;
   } pixel_beat_type;

   typedef struct packed {
      logic [7:0]  magnitude;
      logic [9:0]  out_column;
      logic [11:0] out_row;
      logic        frame_end;
   } result_beat_type;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam int ROOT_STEPS = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_ROOT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;     // take the input beat, start line store read
      logic update;     // line stores, window and position advance
      logic square;     // form the sum of squares
      logic root_load;  // load the square root unit
      logic root_step;  // one two-bit step of the root
      logic finish;     // move the result into the output register
   } command_type;

   typedef struct packed {
      logic emit;       // current pixel completes an interior window
      logic out_free;   // output register can take a result this cycle
   } status_type;

endpackage

[hdl/sobel_datapath.sv]
// Datapath of the Sobel block: line stores, window, position counters,
// gradient arithmetic, square root unit and output register.
// Depends on sobel_pkg.
module sobel_datapath #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sobel_pkg::pixel_beat_type req_data,
   input  logic                      csr_valid,
   input  logic                      csr_index,
   input  logic [11:0]               csr_data,
   input  sobel_pkg::command_type    cmd,
   output sobel_pkg::status_type     status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output sobel_pkg::result_beat_type rsp_data
);
   import sobel_pkg::*;

   localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMPW = ($clog2(MAX_WIDTH + 1) + 1 > 12) ? $clog2(MAX_WIDTH + 1) + 1 : 12;
   localparam logic [CMPW-1:0] MAX_W = CMPW'(MAX_WIDTH);

   logic [10:0] frame_width_ff;
   logic [11:0] frame_height_ff;

   logic [7:0] upper_mem [MAX_WIDTH];
   logic [7:0] middle_mem [MAX_WIDTH];
   logic [7:0] upper_rd_ff, middle_rd_ff;

   logic [7:0]    win_ff [6];
   logic [AW-1:0] column_ff;
   logic [11:0]   row_ff;
   logic [7:0]    pix_ff;
   logic [AW-1:0] cur_col_ff;
   logic [11:0]   cur_row_ff;

   logic [AW-1:0]   col_in;
   logic [11:0]     row_in;
   logic [CMPW-1:0] w_eff, col_ext, col_next;
   logic [11:0]     h_eff;
   logic [12:0]     row_next;

   logic signed [10:0] gx_ff, gy_ff;
   logic [9:0]         res_col_ff;
   logic [11:0]        res_row_ff;
   logic               res_end_ff;
   logic [20:0]        sq_ff;
   logic               sat_ff;
   logic [16:0]        v_ff, r_ff, b_ff;
   logic [16:0]        trial;

   logic            rsp_valid_ff;
   result_beat_type rsp_data_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 11'd1024;
         frame_height_ff <= 12'd1024;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[10:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (CMPW'(frame_width_ff) < CMPW'(3))
         w_eff = CMPW'(3);
      else if (CMPW'(frame_width_ff) > MAX_W)
         w_eff = MAX_W;
      else
         w_eff = CMPW'(frame_width_ff);
      h_eff = (frame_height_ff < 12'd3) ? 12'd3 : frame_height_ff;
   end

   // Position of the incoming pixel, after frame start and range clamp.
   always_comb begin
      col_in = req_data.frame_start ? '0 : column_ff;
      row_in = req_data.frame_start ? '0 : row_ff;
      if (CMPW'(col_in) >= MAX_W)
         col_in = '0;
   end

   always_comb begin
      col_ext  = CMPW'(cur_col_ff);
      col_next = col_ext + CMPW'(1);
      row_next = {1'b0, cur_row_ff} + 13'd1;
   end

   assign status.emit = (col_ext >= CMPW'(2)) && (cur_row_ff >= 12'd2) &&
                        (col_ext < w_eff) && (cur_row_ff < h_eff);

   // Line stores: read at accept, written back in the update cycle.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         upper_rd_ff  <= upper_mem[col_in];
         middle_rd_ff <= middle_mem[col_in];
      end
      if (cmd.update) begin
         upper_mem[cur_col_ff]  <= middle_rd_ff;
         middle_mem[cur_col_ff] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff     <= req_data.pixel;
         cur_col_ff <= col_in;
         cur_row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
         column_ff <= '0;
         row_ff    <= '0;
      end else if (cmd.update) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= upper_rd_ff;
         win_ff[4] <= middle_rd_ff;
         win_ff[5] <= pix_ff;
         if (col_next >= w_eff) begin
            column_ff <= '0;
            row_ff    <= (row_next >= {1'b0, h_eff}) ? 12'd0 : row_next[11:0];
         end else begin
            column_ff <= col_next[AW-1:0];
            row_ff    <= cur_row_ff;
         end
      end
   end

   // Gradient sums, formed while the window still holds the old columns.
   always_ff @(posedge clock) begin
      logic [9:0] left_s, right_s, top_s, bottom_s;
      left_s   = 10'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + 10'(win_ff[2]);
      right_s  = 10'(upper_rd_ff) + {1'b0, middle_rd_ff, 1'b0} + 10'(pix_ff);
      top_s    = 10'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + 10'(upper_rd_ff);
      bottom_s = 10'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + 10'(pix_ff);
      if (cmd.update) begin
         gx_ff      <= $signed({1'b0, left_s}) - $signed({1'b0, right_s});
         gy_ff      <= $signed({1'b0, top_s}) - $signed({1'b0, bottom_s});
         res_col_ff <= 10'(col_ext - CMPW'(1));
         res_row_ff <= cur_row_ff - 12'd1;
         res_end_ff <= (col_ext == w_eff - CMPW'(1)) && (cur_row_ff == h_eff - 12'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.square)
         sq_ff <= 21'(gx_ff * gx_ff) + 21'(gy_ff * gy_ff);
   end

   // Square root, two bits of the radicand per step. Anything at or above
   // 2^16 saturates, so only the low 16 bits are rooted.
   assign trial = r_ff + b_ff;

   always_ff @(posedge clock) begin
      if (cmd.root_load) begin
         sat_ff <= |sq_ff[20:16];
         v_ff   <= {1'b0, sq_ff[15:0]};
         r_ff   <= '0;
         b_ff   <= 17'h04000;
      end else if (cmd.root_step) begin
         if (v_ff >= trial) begin
            v_ff <= v_ff - trial;
            r_ff <= (r_ff >> 1) + b_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         b_ff <= b_ff >> 2;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff.magnitude  <= sat_ff ? 8'd255 : r_ff[7:0];
         rsp_data_ff.out_column <= res_col_ff;
         rsp_data_ff.out_row    <= res_row_ff;
         rsp_data_ff.frame_end  <= res_end_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/sobel_ctrl.sv]
// Controller of the Sobel block: sequences read, update, square and root
// steps for one pixel beat. Depends on sobel_pkg.
module sobel_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sobel_pkg::status_type  status,
   output sobel_pkg::command_type cmd
);
   import sobel_pkg::*;

   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            cmd.update = 1'b1;
            state_in   = status.emit ? ST_SQUARE : ST_IDLE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_ROOT;
            step_in    = '0;
         end
         ST_ROOT: begin
            // The first cycle loads the settled sum of squares, the rest step the root.
            if (step_ff == 4'd0)
               cmd.root_load = 1'b1;
            else
               cmd.root_step = 1'b1;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(ROOT_STEPS))
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic loaded_ff;
   always_ff @(posedge clock) begin
      if (reset)
         loaded_ff <= 1'b0;
      else if (cmd.root_load)
         loaded_ff <= 1'b1;
      else if (cmd.finish)
         loaded_ff <= 1'b0;
   end

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("result written while output register is held");

   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_READ))
      else $error("accepted beat not followed by line store update");

   a_step_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.root_step |-> loaded_ff)
      else $error("root step without a loaded radicand");

endmodule

[hdl/sobel_edge_magnitude.sv]
// Top level of the Sobel 3x3 gradient magnitude block: controller plus
// datapath. Depends on sobel_pkg, sobel_ctrl and sobel_datapath.
//
//   channel  direction  payload                 handshake
//   req      in         pixel, frame_start      req_valid / req_ready
//   rsp      out        magnitude, column, row  rsp_valid / rsp_ready
//   csr      in         index, 12-bit data      csr_valid / csr_ready
//
// A beat that yields no result passes through line store read and update.
// An interior pixel passes through read, update, square, root load, eight
// steps of the two-bit square root unit, which sets the rate, and the move
// into the output register. Synchronous reset clears position and window,
// resets config to 1024; line stores are not cleared. A result waiting in
// the output register stalls only the next interior pixel at its final
// step; csr writes are always taken.
module sobel_edge_magnitude #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  sobel_pkg::pixel_beat_type  req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output sobel_pkg::result_beat_type rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [11:0]                csr_data
);
   import sobel_pkg::*;

   command_type cmd;
   status_type  status;

   assign csr_ready = 1'b1;

   sobel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sobel_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
